FILE: rtl/core/fcd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fcd_pkg;

    // Relay count; the latch holds up to eight relays.
    localparam int NUM_RELAYS = 4;
    localparam int RELAY_LATCH_W = 8;
    localparam int RELAY_IDX_W = 3;
    localparam int RELAY_OUT_W = 4;

    // Payload fields: command, id, device, status.
    localparam int NUM_FIELDS = 4;
    localparam int FIELD_IDX_W = 2;
    localparam int FIELD_NUM_W = 3;

    localparam int FIELD_COMMAND = 0;
    localparam int FIELD_ID = 1;
    localparam int FIELD_DEVICE = 2;
    localparam int FIELD_STATUS = 3;

    // Character codes.
    localparam logic [7:0] CHAR_F = 8'h46;
    localparam logic [7:0] CHAR_R = 8'h52;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_SEP = 8'h2F;
    localparam logic [7:0] CHAR_FILL = 8'h3F;
    localparam logic [7:0] CHAR_ZERO = 8'd48;

    localparam logic [7:0] CMD_SET_RELAY = 8'd2;
    localparam logic [7:0] SLAVE_ID_RESET = 8'd1;

    localparam logic [1:0] DATA_COUNT_FULL = 2'd3;

    typedef logic [NUM_FIELDS-1:0][7:0] field_vals_t;

    // One result transaction.
    typedef struct packed {
        logic [RELAY_OUT_W-1:0] relay_bits;
        logic                   frame_end;
        logic                   command_applied;
        logic                   in_frame;
    } result_t;

endpackage

`default_nettype wire

FILE: rtl/core/frame_command_decoder.sv
// A byte accepted on s_ is held in the input register, then moves through the
// result register to m_; a full result register can hold it in between.
// Throughput: one byte per cycle; the input register and the result register
// both advance whenever the result register is free or being taken.
// Reset (aresetn low, synchronous): both registers empty, marker window '?',
// no frame open, fields zero, relays low, slave_id 1.
`timescale 1ns / 1ps
`default_nettype none

module frame_command_decoder (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output      logic       s_ready,
    input  wire logic [7:0] s_rx_byte,
    output      logic       m_valid,
    input  wire logic       m_ready,
    output      logic [3:0] m_relay_bits,
    output      logic       m_frame_end,
    output      logic       m_command_applied,
    output      logic       m_in_frame,
    input  wire logic       cfg_valid,
    output      logic       cfg_ready,
    input  wire logic [7:0] cfg_slave_id
);

    logic               in_valid_reg;
    logic [7:0]         in_byte_reg;
    logic               out_valid_reg;
    fcd_pkg::result_t   out_reg;
    fcd_pkg::result_t   result;
    logic [7:0]         slave_id_reg;
    logic               advance;

    // The held byte moves on when the result register is free or draining.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    // Configuration register.
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slave_id_reg <= fcd_pkg::SLAVE_ID_RESET;
        end else if (cfg_valid) begin
            slave_id_reg <= cfg_slave_id;
        end
    end

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_rx_byte;
        end
    end

    fcd_core u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step     (advance),
        .rx_byte  (in_byte_reg),
        .slave_id (slave_id_reg),
        .result   (result)
    );

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= result;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_relay_bits      = out_reg.relay_bits;
    assign m_frame_end       = out_reg.frame_end;
    assign m_command_applied = out_reg.command_applied;
    assign m_in_frame        = out_reg.in_frame;

endmodule

`default_nettype wire

FILE: rtl/core/fcd_field_acc.sv
`timescale 1ns / 1ps
`default_nettype none

module fcd_field_acc (
    input  wire logic                            take,
    input  wire logic [7:0]                      data_byte,
    input  wire logic [fcd_pkg::FIELD_NUM_W-1:0] field_num,
    input  wire fcd_pkg::field_vals_t            field_vals,
    output      logic [fcd_pkg::FIELD_NUM_W-1:0] field_num_next,
    output      fcd_pkg::field_vals_t            field_vals_next
);

    logic                              field_open;
    logic [fcd_pkg::FIELD_IDX_W-1:0]   field_idx;
    logic [7:0]                        cur_val;
    logic [7:0]                        acc_val;

    assign field_open = (field_num < fcd_pkg::FIELD_NUM_W'(fcd_pkg::NUM_FIELDS));
    assign field_idx  = field_num[fcd_pkg::FIELD_IDX_W-1:0];
    assign cur_val    = field_vals[field_idx];

    // value * 10 + byte - '0', all modulo 256.
    assign acc_val = {cur_val[4:0], 3'b000} + {cur_val[6:0], 1'b0}
                     + data_byte - fcd_pkg::CHAR_ZERO;

    // A separator advances to the next field; other bytes feed the current one.
    always_comb begin
        field_num_next  = field_num;
        field_vals_next = field_vals;
        if (take && field_open) begin
            if (data_byte == fcd_pkg::CHAR_SEP) begin
                field_num_next = field_num + fcd_pkg::FIELD_NUM_W'(1);
            end else begin
                field_vals_next[field_idx] = acc_val;
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/fcd_core.sv
`timescale 1ns / 1ps
`default_nettype none

module fcd_core (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               step,
    input  wire logic [7:0]         rx_byte,
    input  wire logic [7:0]         slave_id,
    output      fcd_pkg::result_t   result
);

    logic [7:0]                        win_reg [3];
    logic [7:0]                        win_next [3];
    logic                              open_reg;
    logic                              open_next;
    logic [1:0]                        count_reg;
    logic [1:0]                        count_next;
    logic [fcd_pkg::FIELD_NUM_W-1:0]   fnum_reg;
    logic [fcd_pkg::FIELD_NUM_W-1:0]   fnum_next;
    fcd_pkg::field_vals_t              fvals_reg;
    fcd_pkg::field_vals_t              fvals_next;
    logic [fcd_pkg::RELAY_LATCH_W-1:0] latch_reg;
    logic [fcd_pkg::RELAY_LATCH_W-1:0] latch_next;

    logic                              take;
    logic [fcd_pkg::FIELD_NUM_W-1:0]   acc_fnum;
    fcd_pkg::field_vals_t              acc_fvals;
    logic                              start_seen;
    logic                              stop_seen;
    logic [7:0]                        dev;
    logic                              cmd_match;
    logic [fcd_pkg::RELAY_IDX_W-1:0]   relay_idx;
    logic [fcd_pkg::RELAY_LATCH_W-1:0] relay_mask;
    logic                              frame_end;
    logic                              applied;

    // Window after shifting in the new byte.
    assign win_next[0] = win_reg[1];
    assign win_next[1] = win_reg[2];
    assign win_next[2] = rx_byte;

    assign start_seen = (win_next[0] == fcd_pkg::CHAR_F) && (win_next[1] == fcd_pkg::CHAR_R)
                        && (win_next[2] == fcd_pkg::CHAR_COLON);
    assign stop_seen  = (win_next[0] == fcd_pkg::CHAR_COLON) && (win_next[1] == fcd_pkg::CHAR_F)
                        && (win_next[2] == fcd_pkg::CHAR_R);

    // The byte leaving the window is payload once three bytes followed the start.
    assign take = open_reg && (count_reg == fcd_pkg::DATA_COUNT_FULL);

    fcd_field_acc u_field_acc (
        .take            (take),
        .data_byte       (win_reg[0]),
        .field_num       (fnum_reg),
        .field_vals      (fvals_reg),
        .field_num_next  (acc_fnum),
        .field_vals_next (acc_fvals)
    );

    // Command check on the fields as they stand after this byte.
    assign dev       = acc_fvals[fcd_pkg::FIELD_DEVICE];
    assign cmd_match = (acc_fvals[fcd_pkg::FIELD_COMMAND] == fcd_pkg::CMD_SET_RELAY)
                       && (acc_fvals[fcd_pkg::FIELD_ID] == slave_id)
                       && (dev != 8'd0)
                       && (dev <= 8'(fcd_pkg::NUM_RELAYS));
    assign relay_idx  = fcd_pkg::RELAY_IDX_W'(dev - 8'd1);
    assign relay_mask = fcd_pkg::RELAY_LATCH_W'(1) << relay_idx;

    assign frame_end = open_reg && stop_seen;
    assign applied   = frame_end && cmd_match;

    // Next frame state.
    always_comb begin
        open_next  = open_reg;
        count_next = count_reg;
        fnum_next  = fnum_reg;
        fvals_next = fvals_reg;
        latch_next = latch_reg;
        if (!open_reg) begin
            if (start_seen) begin
                open_next  = 1'b1;
                count_next = 2'd0;
            end
        end else begin
            fnum_next  = acc_fnum;
            fvals_next = acc_fvals;
            if (count_reg != fcd_pkg::DATA_COUNT_FULL) begin
                count_next = count_reg + 2'd1;
            end
            if (applied) begin
                if (acc_fvals[fcd_pkg::FIELD_STATUS] != 8'd0) begin
                    latch_next = latch_reg | relay_mask;
                end else begin
                    latch_next = latch_reg & ~relay_mask;
                end
            end
            if (stop_seen) begin
                open_next  = 1'b0;
                count_next = 2'd0;
                fnum_next  = '0;
                fvals_next = '0;
            end
        end
    end

    // Frame state registers, updated once per processed byte.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg[0] <= fcd_pkg::CHAR_FILL;
            win_reg[1] <= fcd_pkg::CHAR_FILL;
            win_reg[2] <= fcd_pkg::CHAR_FILL;
            open_reg   <= 1'b0;
            count_reg  <= 2'd0;
            fnum_reg   <= '0;
            fvals_reg  <= '0;
            latch_reg  <= '0;
        end else if (step) begin
            if (frame_end) begin
                win_reg[0] <= fcd_pkg::CHAR_FILL;
                win_reg[1] <= fcd_pkg::CHAR_FILL;
                win_reg[2] <= fcd_pkg::CHAR_FILL;
            end else begin
                win_reg[0] <= win_next[0];
                win_reg[1] <= win_next[1];
                win_reg[2] <= win_next[2];
            end
            open_reg  <= open_next;
            count_reg <= count_next;
            fnum_reg  <= fnum_next;
            fvals_reg <= fvals_next;
            latch_reg <= latch_next;
        end
    end

    // Result fields for this byte.
    assign result.relay_bits      = latch_next[fcd_pkg::RELAY_OUT_W-1:0];
    assign result.frame_end       = frame_end;
    assign result.command_applied = applied;
    assign result.in_frame        = open_next;

endmodule

`default_nettype wire

FILE: verif/frame_command_decoder_checker.sv
`timescale 1ns / 1ps

// Watches the byte, result and slave_id channels of frame_command_decoder,
// keeps its own copy of the decoder state and checks every result transaction.
module frame_command_decoder_checker
    import fcd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_ready,
    input  logic [7:0] s_rx_byte,
    input  logic       m_valid,
    input  logic       m_ready,
    input  logic [3:0] m_relay_bits,
    input  logic       m_frame_end,
    input  logic       m_command_applied,
    input  logic       m_in_frame,
    input  logic       cfg_valid,
    input  logic       cfg_ready,
    input  logic [7:0] cfg_slave_id,
    output int         mismatches,
    output int         outstanding
);

    // Shadow copy of the decoder state.
    logic [7:0]               mark_win [3];
    logic                     frame_open_q;
    logic [1:0]               lead_cnt;
    logic [FIELD_NUM_W-1:0]   fld_idx;
    field_vals_t              fld_val;
    logic [RELAY_LATCH_W-1:0] relay_q;
    logic [7:0]               node_id;

    // Results that the decoder still owes, oldest first.
    result_t pending_results [$];
    int      err_cnt = 0;

    task automatic clear_frame_state();
        for (int i = 0; i < 3; i++) begin
            mark_win[i] = CHAR_FILL;
        end
        frame_open_q = 1'b0;
        lead_cnt = '0;
        fld_idx = '0;
        fld_val = '0;
    endtask

    // A payload byte either moves to the next field or is folded into the
    // current one as a decimal digit, with no range check and 8-bit wrap.
    task automatic absorb_payload(input logic [7:0] b);
        if (b == CHAR_SEP) begin
            if (fld_idx < NUM_FIELDS) begin
                fld_idx++;
            end
        end else if (fld_idx < NUM_FIELDS) begin
            fld_val[fld_idx[FIELD_IDX_W-1:0]] =
                fld_val[fld_idx[FIELD_IDX_W-1:0]] * 8'd10 + b - CHAR_ZERO;
        end
    endtask

    // Advances the shadow state by one received byte and forms its result.
    task automatic decode_byte(input logic [7:0] b, output result_t r);
        logic [7:0] leaving;
        logic [7:0] dev;
        r = '0;
        leaving = mark_win[0];
        mark_win[0] = mark_win[1];
        mark_win[1] = mark_win[2];
        mark_win[2] = b;

        if (!frame_open_q) begin
            if (mark_win[0] == CHAR_F && mark_win[1] == CHAR_R && mark_win[2] == CHAR_COLON) begin
                frame_open_q = 1'b1;
                lead_cnt = '0;
            end
        end else begin
            // Bytes become payload only once they drop out of the window.
            if (lead_cnt == DATA_COUNT_FULL) begin
                absorb_payload(leaving);
            end else begin
                lead_cnt++;
            end

            if (mark_win[0] == CHAR_COLON && mark_win[1] == CHAR_F && mark_win[2] == CHAR_R) begin
                dev = fld_val[FIELD_DEVICE];
                r.frame_end = 1'b1;
                if (fld_val[FIELD_COMMAND] == CMD_SET_RELAY && fld_val[FIELD_ID] == node_id &&
                    dev >= 8'd1 && dev <= NUM_RELAYS) begin
                    relay_q[dev[RELAY_IDX_W-1:0] - 3'd1] = (fld_val[FIELD_STATUS] != 8'd0);
                    r.command_applied = 1'b1;
                end
                clear_frame_state();
            end
        end

        r.relay_bits = relay_q[RELAY_OUT_W-1:0];
        r.in_frame = frame_open_q;
    endtask

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (want !== got) begin
            err_cnt++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    // Predict on every accepted byte, compare on every accepted result.
    always @(posedge aclk) begin : track
        result_t want;
        if (!aresetn) begin
            node_id = SLAVE_ID_RESET;
            relay_q = '0;
            clear_frame_state();
            pending_results.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                node_id = cfg_slave_id;
            end
            if (s_valid && s_ready) begin
                decode_byte(s_rx_byte, want);
                pending_results.push_back(want);
            end
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    err_cnt++;
                    $display("%0t: unexpected result, expected none, actual %0h/%0b/%0b/%0b",
                             $time, m_relay_bits, m_frame_end, m_command_applied, m_in_frame);
                end else begin
                    want = pending_results.pop_front();
                    check_field("relay_bits", 8'(want.relay_bits), 8'(m_relay_bits));
                    check_field("frame_end", 8'(want.frame_end), 8'(m_frame_end));
                    check_field("command_applied", 8'(want.command_applied),
                                8'(m_command_applied));
                    check_field("in_frame", 8'(want.in_frame), 8'(m_in_frame));
                end
            end
        end
        mismatches <= err_cnt;
        outstanding <= pending_results.size();
    end

endmodule

FILE: verif/frame_command_decoder_tb.sv
`timescale 1ns / 1ps

module frame_command_decoder_tb;
    import fcd_pkg::*;

    localparam int RESET_CYCLES = 7;
    localparam int SETTLE_CYCLES = 4;
    localparam int IDLE_LIMIT = 1000;
    localparam int NUM_PHASES = 5;
    localparam int PHASE_ITEMS = 90;

    logic       aclk;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_rx_byte = 8'h00;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [3:0] m_relay_bits;
    logic       m_frame_end;
    logic       m_command_applied;
    logic       m_in_frame;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [7:0] cfg_slave_id = 8'h00;

    int         mismatches;
    int         outstanding;
    int         n_sent = 0;
    bit         steady = 1'b0;
    logic [7:0] node_id_now = SLAVE_ID_RESET;

    frame_command_decoder u_top (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_rx_byte         (s_rx_byte),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_relay_bits      (m_relay_bits),
        .m_frame_end       (m_frame_end),
        .m_command_applied (m_command_applied),
        .m_in_frame        (m_in_frame),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_slave_id      (cfg_slave_id)
    );

    frame_command_decoder_checker u_checker (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_rx_byte         (s_rx_byte),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_relay_bits      (m_relay_bits),
        .m_frame_end       (m_frame_end),
        .m_command_applied (m_command_applied),
        .m_in_frame        (m_in_frame),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_slave_id      (cfg_slave_id),
        .mismatches        (mismatches),
        .outstanding       (outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Idle length: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Result side: bursts of ready broken by random stalls.
    initial begin : result_sink
        int hold;
        int gap;
        @(posedge aclk);
        forever begin
            m_ready <= 1'b1;
            if (steady) begin
                hold = 1;
            end else if ($urandom_range(0, 9) == 0) begin
                hold = $urandom_range(30, 80);
            end else begin
                hold = $urandom_range(1, 16);
            end
            repeat (hold) @(posedge aclk);
            gap = pick_gap();
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    end

    // Ends the run when no transaction of any kind moves for too long.
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("Some tests failed");
        $finish;
    end

    // One byte transaction; valid stays high afterwards unless a gap follows.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_rx_byte <= b;
        do @(posedge aclk); while (!s_ready);
        n_sent++;
    endtask

    task automatic send_text(input string t);
        for (int i = 0; i < t.len(); i++) begin
            send_byte(t[i]);
        end
    endtask

    task automatic send_number(input int unsigned v);
        send_text($sformatf("%0d", v));
    endtask

    task automatic send_digits(input int count);
        repeat (count) send_byte(8'(CHAR_ZERO + $urandom_range(0, 9)));
    endtask

    task automatic send_start();
        send_byte(CHAR_F);
        send_byte(CHAR_R);
        send_byte(CHAR_COLON);
    endtask

    task automatic send_stop();
        send_byte(CHAR_COLON);
        send_byte(CHAR_F);
        send_byte(CHAR_R);
    endtask

    // Lets every owed result come out before the decoder is reconfigured or the run ends.
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_node_id(input logic [7:0] v);
        drain();
        cfg_valid <= 1'b1;
        cfg_slave_id <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        node_id_now = v;
    endtask

    // Content of one field, mostly what a real master would send.
    task automatic send_field(input int f);
        int r;
        r = $urandom_range(0, 99);
        case (f)
            FIELD_COMMAND: begin
                if (r < 85) send_number(CMD_SET_RELAY);
                else if (r < 95) send_number($urandom_range(0, 12));
                else send_digits($urandom_range(0, 5));
            end
            FIELD_ID: begin
                // Empty id reads zero; adding 256 wraps back to the same id.
                if (r < 60) send_number(node_id_now);
                else if (r < 70) send_number(node_id_now + 256 * $urandom_range(1, 3));
                else if (r < 78) send_text("");
                else send_number($urandom_range(0, 255));
            end
            FIELD_DEVICE: begin
                if (r < 80) send_number($urandom_range(1, NUM_RELAYS));
                else if (r < 88) send_number(0);
                else if (r < 95) send_number($urandom_range(NUM_RELAYS + 1, 9));
                else send_digits($urandom_range(1, 6));
            end
            default: begin
                if (r < 40) send_number(0);
                else if (r < 75) send_number(1);
                else if (r < 85) send_number($urandom_range(2, 999));
                else if (r < 92) send_text("");
                else send_byte(8'($urandom_range(0, 255)));
            end
        endcase
    endtask

    // A command frame, sometimes short of fields or with extra ones.
    task automatic send_command_frame();
        int last_field;
        repeat ($urandom_range(0, 2)) send_byte(8'($urandom_range(0, 255)));
        send_start();
        if ($urandom_range(0, 99) < 85) begin
            last_field = FIELD_STATUS;
        end else begin
            last_field = $urandom_range(FIELD_COMMAND, FIELD_STATUS);
        end
        for (int f = FIELD_COMMAND; f <= last_field; f++) begin
            if (f != FIELD_COMMAND) send_byte(CHAR_SEP);
            send_field(f);
        end
        // Fields past status are ignored, a start marker among them too.
        if ($urandom_range(0, 99) < 15) begin
            send_byte(CHAR_SEP);
            if ($urandom_range(0, 1) == 0) send_start();
            else send_digits($urandom_range(0, 4));
        end
        send_stop();
    endtask

    // One random stretch of traffic.
    task automatic random_segment();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) begin
            send_command_frame();
        end else if (r < 72) begin
            // Stop sharing its colon with the start.
            send_start();
            send_byte(CHAR_F);
            send_byte(CHAR_R);
        end else if (r < 82) begin
            case ($urandom_range(0, 3))
                0: begin
                    send_byte(CHAR_F);
                    send_byte(CHAR_R);
                    send_byte(8'($urandom_range(0, 255)));
                end
                1: begin
                    send_start();
                    send_digits($urandom_range(1, 5));
                end
                2: send_stop();
                default: begin
                    send_start();
                    send_digits($urandom_range(0, 3));
                    send_byte(CHAR_COLON);
                    send_byte(CHAR_F);
                end
            endcase
        end else begin
            repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
        end
    endtask

    initial begin : stimulus
        logic [7:0] next_id;
        int phase_end;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // Byte extremes, an empty frame whose stop shares the colon, a colon
        // right after the stop, then a frame that sets relay 3.
        send_byte(8'h00);
        send_byte(8'hFF);
        send_start();
        send_byte(CHAR_F);
        send_byte(CHAR_R);
        send_byte(CHAR_COLON);
        send_start();
        send_number(CMD_SET_RELAY);
        send_byte(CHAR_SEP);
        send_number(node_id_now);
        send_byte(CHAR_SEP);
        send_number(3);
        send_byte(CHAR_SEP);
        send_number(7);
        send_stop();

        // Random traffic under several node ids, one phase without idling.
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            if (phase > 0) begin
                case (phase)
                    1: next_id = 8'd0;
                    2: next_id = 8'd255;
                    3: next_id = 8'($urandom_range(2, 254));
                    default: next_id = SLAVE_ID_RESET;
                endcase
                set_node_id(next_id);
            end
            steady = (phase == 2);
            phase_end = n_sent + PHASE_ITEMS;
            while (n_sent < phase_end) random_segment();
        end
        steady = 1'b0;
        drain();

        if (mismatches == 0 && outstanding == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
